### rtl/core/lpr_pkg.sv
// ----------------------------------------------------------------------------
// LRU page replacement package
// Payload types and fixed constants shared by the page replacement block.
// ----------------------------------------------------------------------------
`default_nettype none

package lpr_pkg;

  localparam int unsigned PAGE_W   = 16;
  localparam int unsigned FRAME_W  = 6;
  localparam int unsigned COUNT_W  = 32;
  localparam int unsigned ACTIVE_W = 7;

  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 7'd16;
  localparam logic [COUNT_W-1:0]  COUNT_MAX    = {COUNT_W{1'b1}};

  typedef struct packed {
    logic [PAGE_W-1:0] page_number;
  } page_in_t;

  typedef struct packed {
    logic               hit;
    logic [FRAME_W-1:0] frame_index;
    logic               evicted_valid;
    logic [PAGE_W-1:0]  evicted_page;
    logic [COUNT_W-1:0] hit_count;
    logic [COUNT_W-1:0] fault_count;
  } result_t;

  typedef struct packed {
    logic [ACTIVE_W-1:0] active_frames;
  } cfg_t;

endpackage

`default_nettype wire

### rtl/core/lpr_chan_if.sv
// ----------------------------------------------------------------------------
// LRU page replacement channel
// Valid/ready channel carrying one payload beat of a given type.
// ----------------------------------------------------------------------------
`default_nettype none

interface lpr_chan_if #(
  parameter type T = logic
);

  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

### rtl/core/lru_page_replacement.sv
// ----------------------------------------------------------------------------
// LRU page replacement
// Fully associative page frame table with per-frame age counters.
// ----------------------------------------------------------------------------
// A page beat is taken only while the sequencer is idle. Its result is
// registered after a walk through active_frames entries of the frame RAM
// (clamped to 1..FRAMES), a fix step that writes the victim on a fault, and
// a result step. A new beat is taken only once the last result is registered;
// a result still waiting holds the next one back.
// Reset clears all valid bits, both counters and sets active_frames to 16.
`default_nettype none

module lru_page_replacement
  import lpr_pkg::*;
#(
  parameter int unsigned FRAMES    = 16,
  parameter int unsigned PAGE_BITS = 16,
  parameter int unsigned AGE_BITS  = 16
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  lpr_chan_if.sink   cfg_ch,
  lpr_chan_if.sink   in_ch,
  lpr_chan_if.source out_ch
);

  localparam int unsigned CNT_W = $clog2(FRAMES + 1);

  logic [ACTIVE_W-1:0] active_r;
  logic [CNT_W-1:0]    n_active;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= ACTIVE_RESET;
    end else if (cfg_ch.valid) begin
      active_r <= cfg_ch.data.active_frames;
    end
  end

  // A count of zero acts as one; anything above the frame count is clamped.
  always_comb begin
    if (active_r == '0) begin
      n_active = CNT_W'(1);
    end else if (32'(active_r) > 32'(FRAMES)) begin
      n_active = CNT_W'(FRAMES);
    end else begin
      n_active = CNT_W'(active_r);
    end
  end

  lpr_ctrl #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS),
    .AGE_BITS  (AGE_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .n_active (n_active),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire

### rtl/core/lpr_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module lpr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/core/lpr_ctrl.sv
// ----------------------------------------------------------------------------
// LRU page replacement sequencer
// Walks the frame table once per beat: ages, matches and tracks the victim,
// then writes the new page on a fault and issues the result.
// ----------------------------------------------------------------------------
`default_nettype none

module lpr_ctrl
  import lpr_pkg::*;
#(
  parameter int unsigned FRAMES    = 16,
  parameter int unsigned PAGE_BITS = 16,
  parameter int unsigned AGE_BITS  = 16,
  localparam int unsigned IDX_W    = (FRAMES > 1) ? $clog2(FRAMES) : 1,
  localparam int unsigned CNT_W    = $clog2(FRAMES + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [CNT_W-1:0] n_active,
  lpr_chan_if.sink              in_ch,
  lpr_chan_if.source            out_ch
);

  localparam int unsigned ENT_W = AGE_BITS + PAGE_BITS;
  localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_FIX, S_DONE} state_t;

  state_t               state_r, state_nxt;
  logic [PAGE_BITS-1:0] page_r;
  logic [CNT_W-1:0]     n_r;
  logic [CNT_W-1:0]     rd_cnt_r;
  logic                 rd_pend_r;
  logic [IDX_W-1:0]     rd_idx_r;
  logic                 hit_r;
  logic [IDX_W-1:0]     slot_r;
  logic                 empty_found_r;
  logic [IDX_W-1:0]     empty_idx_r;
  logic [IDX_W-1:0]     max_idx_r;
  logic [AGE_BITS-1:0]  max_age_r;
  logic [PAGE_BITS-1:0] max_page_r;
  logic [COUNT_W-1:0]   hits_r;
  logic [COUNT_W-1:0]   faults_r;
  logic [FRAMES-1:0]    vld_r;
  result_t              out_r;
  logic                 out_vld_r;

  logic                 rd_issue;
  logic [ENT_W-1:0]     rdata;
  logic                 cur_v;
  logic [AGE_BITS-1:0]  cur_age;
  logic [PAGE_BITS-1:0] cur_page;
  logic                 cur_match;
  logic [AGE_BITS-1:0]  cur_new_age;
  logic [IDX_W-1:0]     victim_idx;
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [ENT_W-1:0]     ram_wdata;
  logic                 out_free;
  result_t              res;

  lpr_ram #(
    .WIDTH (ENT_W),
    .DEPTH (FRAMES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_cnt_r[IDX_W-1:0]),
    .rdata (rdata)
  );

  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = out_vld_r;
  assign out_ch.data  = out_r;

  assign rd_issue    = (state_r == S_WALK) && (rd_cnt_r < n_r);
  assign cur_v       = vld_r[rd_idx_r];
  assign cur_age     = rdata[ENT_W-1 -: AGE_BITS];
  assign cur_page    = rdata[PAGE_BITS-1:0];
  assign cur_match   = cur_v && (cur_page == page_r);
  assign cur_new_age = cur_match ? AGE_BITS'(1) :
                       ((cur_age == AGE_MAX) ? cur_age : cur_age + 1'b1);
  assign victim_idx  = empty_found_r ? empty_idx_r : max_idx_r;
  assign out_free    = !out_vld_r || out_ch.ready;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = rd_idx_r;
    ram_wdata = {cur_new_age, cur_page};
    if (rd_pend_r) begin
      ram_we = 1'b1;
    end else if ((state_r == S_FIX) && !hit_r) begin
      ram_we    = 1'b1;
      ram_waddr = victim_idx;
      ram_wdata = {AGE_BITS'(0), page_r};
    end
  end

  always_comb begin
    res.hit           = hit_r;
    res.frame_index   = FRAME_W'(hit_r ? slot_r : victim_idx);
    res.evicted_valid = !hit_r && !empty_found_r;
    res.evicted_page  = res.evicted_valid ? PAGE_W'(max_page_r) : '0;
    res.hit_count     = hits_r;
    res.fault_count   = faults_r;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (!rd_issue && !rd_pend_r) begin
          state_nxt = S_FIX;
        end
      end
      S_FIX: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      rd_pend_r <= 1'b0;
      vld_r     <= '0;
      hits_r    <= '0;
      faults_r  <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if ((state_r == S_IDLE) && in_ch.valid) begin
        page_r        <= PAGE_BITS'(in_ch.data.page_number);
        n_r           <= n_active;
        rd_cnt_r      <= '0;
        rd_pend_r     <= 1'b0;
        hit_r         <= 1'b0;
        empty_found_r <= 1'b0;
        max_age_r     <= '0;
        max_idx_r     <= '0;
      end

      if (state_r == S_WALK) begin
        rd_pend_r <= rd_issue;
        if (rd_issue) begin
          rd_cnt_r <= rd_cnt_r + 1'b1;
          rd_idx_r <= rd_cnt_r[IDX_W-1:0];
        end
      end

      if (rd_pend_r) begin
        if (cur_match) begin
          hit_r <= 1'b1;
          if (!hit_r) begin
            slot_r <= rd_idx_r;
          end
        end
        if (!cur_v && !empty_found_r) begin
          empty_found_r <= 1'b1;
          empty_idx_r   <= rd_idx_r;
        end
        if (cur_v && (cur_new_age > max_age_r)) begin
          max_age_r  <= cur_new_age;
          max_idx_r  <= rd_idx_r;
          max_page_r <= cur_page;
        end
      end

      if (state_r == S_FIX) begin
        if (hit_r) begin
          if (hits_r != COUNT_MAX) begin
            hits_r <= hits_r + 1'b1;
          end
        end else begin
          vld_r[victim_idx] <= 1'b1;
          if (faults_r != COUNT_MAX) begin
            faults_r <= faults_r + 1'b1;
          end
        end
      end

      if ((state_r == S_DONE) && out_free) begin
        out_r     <= res;
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire
